>>> rtl/pem_pkg.sv
// pem_pkg: shared types, codes and defaults for the passcode entry matcher
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package pem_pkg;

  localparam int CODE_LEN_DEF    = 4;
  localparam int TABLE_DEPTH_DEF = 16;

  localparam int CHAR_W  = 8;
  localparam int CODE_W  = 32;
  localparam int INDEX_W = 4;

  localparam logic [CHAR_W-1:0] ENTER_RESET = 8'd13;

  // item action codes
  localparam logic ACT_KEY   = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  typedef enum logic [2:0] {
    ST_STORED    = 3'd0,
    ST_TOO_LONG  = 3'd1,
    ST_TOO_SHORT = 3'd2,
    ST_GRANTED   = 3'd3,
    ST_DENIED    = 3'd4,
    ST_ACK       = 3'd5,
    ST_WRITTEN   = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } ctrl_state_t;

  // low min(code_len, 4) bytes of the buffer take part in the compare
  function automatic logic [CODE_W-1:0] cmp_mask(input int code_len);
    int nbytes;
    nbytes = (code_len < 4) ? code_len : 4;
    return {CODE_W{1'b1}} >> (CHAR_W * (4 - nbytes));
  endfunction

endpackage

`default_nettype wire

>>> rtl/pem_code_mem.sv
// pem_code_mem: stored code table, one write port and one registered read port
// uses pem_pkg for the code width
`timescale 1ns / 1ps
`default_nettype none

module pem_code_mem
  import pem_pkg::*;
#(
  parameter int DEPTH = TABLE_DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [CODE_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output logic      [CODE_W-1:0] rdata
);

  logic [CODE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/pem_ctrl.sv
// pem_ctrl: entry buffer, slot valid bits, table scan sequencer and result register
// uses pem_pkg; drives the read and write ports of pem_code_mem
`timescale 1ns / 1ps
`default_nettype none

module pem_ctrl
  import pem_pkg::*;
#(
  parameter int CODE_LEN    = CODE_LEN_DEF,
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [CHAR_W-1:0]  enter_code,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               action,
  input  wire logic [CHAR_W-1:0]  key_char,
  input  wire logic [INDEX_W-1:0] entry_index,
  input  wire logic [CODE_W-1:0]  entry_code,
  input  wire logic               entry_valid,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              status,
  output logic [INDEX_W-1:0]      match_index,
  output logic                    mem_we,
  output logic [AW-1:0]           mem_waddr,
  output logic [CODE_W-1:0]       mem_wdata,
  output logic                    mem_re,
  output logic [AW-1:0]           mem_raddr,
  input  wire logic [CODE_W-1:0]  mem_rdata
);

  localparam int CNT_W = $clog2(CODE_LEN + 1);
  localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(CODE_LEN);
  localparam logic [AW-1:0]     LAST     = AW'(TABLE_DEPTH - 1);
  localparam logic [CODE_W-1:0] MASK     = cmp_mask(CODE_LEN);

  ctrl_state_t state, state_next;

  logic [CODE_W-1:0] code_buffer;
  logic [CNT_W-1:0]  char_count;
  logic              awaiting_ack;
  logic [TABLE_DEPTH-1:0] slot_valid;

  logic [AW-1:0] scan_addr;
  logic          issue_on;
  logic          cmp_vld;
  logic [AW-1:0] cmp_idx;
  logic          found;
  logic [AW-1:0] found_idx;

  logic          accept;
  logic          out_free;
  logic          load_done;
  logic          hit;
  logic          scan_end;

  // item decode
  status_t       item_status;
  logic          start_scan;
  logic          clr_entry;
  logic          shift_in;
  logic          ack_clr;

  logic [6:0]       idx_ext;
  logic             wr_in_range;
  logic [AW+3:0]    waddr_wide;
  logic [AW+3:0]    midx_wide;

  assign out_free = !out_valid || !out_stall;
  assign accept   = in_valid && !in_stall;

  assign idx_ext     = {3'd0, entry_index};
  assign wr_in_range = idx_ext < 7'(TABLE_DEPTH);
  assign waddr_wide  = {{AW{1'b0}}, entry_index};
  assign midx_wide   = {4'd0, found_idx};

  assign hit      = cmp_vld && slot_valid[cmp_idx] && (((mem_rdata ^ code_buffer) & MASK) == '0);
  assign scan_end = cmp_vld && (hit || (cmp_idx == LAST));

  always_comb begin
    item_status = ST_STORED;
    start_scan  = 1'b0;
    clr_entry   = 1'b0;
    shift_in    = 1'b0;
    ack_clr     = 1'b0;
    if (action == ACT_WRITE) begin
      item_status = ST_WRITTEN;
    end else if (awaiting_ack) begin
      item_status = ST_ACK;
      ack_clr     = 1'b1;
      clr_entry   = 1'b1;
    end else if (key_char != enter_code) begin
      if (char_count >= FULL_CNT) begin
        item_status = ST_TOO_LONG;
        clr_entry   = 1'b1;
      end else begin
        shift_in = 1'b1;
      end
    end else if (char_count != FULL_CNT) begin
      item_status = ST_TOO_SHORT;
      clr_entry   = 1'b1;
    end else begin
      start_scan = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && start_scan) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall  = 1'b1;
    mem_re    = 1'b0;
    mem_raddr = scan_addr;
    load_done = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_stall = !out_free;
      end
      S_SCAN: begin
        mem_re = issue_on;
      end
      S_DONE: begin
        load_done = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // table writes never overlap a scan: items are taken one at a time
  assign mem_we    = accept && (action == ACT_WRITE) && wr_in_range;
  assign mem_waddr = waddr_wide[AW-1:0];
  assign mem_wdata = entry_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      code_buffer  <= '0;
      char_count   <= '0;
      awaiting_ack <= 1'b0;
      slot_valid   <= '0;
      out_valid    <= 1'b0;
      issue_on     <= 1'b0;
      cmp_vld      <= 1'b0;
      found        <= 1'b0;
    end else begin
      state <= state_next;

      if (mem_we) begin
        slot_valid[mem_waddr] <= entry_valid;
      end

      if (accept) begin
        if (clr_entry) begin
          code_buffer <= '0;
          char_count  <= '0;
        end else if (shift_in) begin
          code_buffer <= {code_buffer[CODE_W-CHAR_W-1:0], key_char};
          char_count  <= char_count + 1'b1;
        end
        if (ack_clr) begin
          awaiting_ack <= 1'b0;
        end
      end

      // scan pipeline: issue one read per cycle, compare the previous one
      if (accept && start_scan) begin
        scan_addr <= '0;
        issue_on  <= 1'b1;
        cmp_vld   <= 1'b0;
        found     <= 1'b0;
      end else if (state == S_SCAN) begin
        cmp_vld <= issue_on && !scan_end;
        cmp_idx <= scan_addr;
        if (issue_on) begin
          if (scan_addr == LAST || scan_end) begin
            issue_on <= 1'b0;
          end else begin
            scan_addr <= scan_addr + 1'b1;
          end
        end
        if (scan_end) begin
          found     <= hit;
          found_idx <= cmp_idx;
        end
      end

      if (load_done) begin
        code_buffer  <= '0;
        char_count   <= '0;
        awaiting_ack <= found;
      end

      if (accept && !start_scan) begin
        out_valid   <= 1'b1;
        status      <= item_status;
        match_index <= '0;
      end else if (load_done) begin
        out_valid   <= 1'b1;
        status      <= found ? ST_GRANTED : ST_DENIED;
        match_index <= found ? midx_wide[INDEX_W-1:0] : '0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/passcode_entry_matcher.sv
// passcode_entry_matcher: top level, enter character register and block wiring
// uses pem_pkg, pem_ctrl and pem_code_mem
`timescale 1ns / 1ps
`default_nettype none

// Digital combination lock. Key items are shifted into a code buffer; the
// enter character (register written on the cfg channel, reset 13) ends an
// entry, and an entry of exactly CODE_LEN characters is compared against
// the stored code table. The lowest valid matching slot answers granted with
// its index, else denied; after a grant the next key item is an acknowledge.
// Table items write one slot and its valid bit. A key or table item's
// result is loaded into the output register at the next edge. A full-length
// enter scans the code memory one slot per cycle through its single read
// port, ending early at the first matching slot. Slot valid bits are flops
// cleared by reset, so no clearing pass is needed. The input is taken while
// a result waits, as long as the output is not stalled and no entry is
// being scanned or answered.
module passcode_entry_matcher
  import pem_pkg::*;
#(
  parameter int CODE_LEN    = CODE_LEN_DEF,
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CHAR_W-1:0]  cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               action,
  input  wire logic [CHAR_W-1:0]  key_char,
  input  wire logic [INDEX_W-1:0] entry_index,
  input  wire logic [CODE_W-1:0]  entry_code,
  input  wire logic               entry_valid,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              status,
  output logic [INDEX_W-1:0]      match_index
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [CHAR_W-1:0] enter_code;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CODE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [CODE_W-1:0] mem_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enter_code <= ENTER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      enter_code <= cfg_data;
    end
  end

  pem_ctrl #(
    .CODE_LEN    (CODE_LEN),
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .enter_code  (enter_code),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .key_char    (key_char),
    .entry_index (entry_index),
    .entry_code  (entry_code),
    .entry_valid (entry_valid),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .match_index (match_index),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  pem_code_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

>>> rtl/pem_checker.sv
// pem_checker: port-level assertions for passcode_entry_matcher, bound to the top
// uses pem_pkg for status and action codes
`timescale 1ns / 1ps
`default_nettype none

module pem_checker
  import pem_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               action,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [2:0]         status,
  input wire logic [INDEX_W-1:0] match_index
);

  // a held result does not change
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(match_index))
    else $error("result changed while stalled");

  // a table item is answered on the next edge
  a_write_resp: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && action == ACT_WRITE |=> out_valid && status == ST_WRITTEN)
    else $error("table item not answered with entry_written");

  // slot index only shows with a grant
  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_GRANTED |-> match_index == '0)
    else $error("nonzero match index without grant");

  // no unused status code
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_WRITTEN)
    else $error("undefined status code");

endmodule

bind passcode_entry_matcher pem_checker u_pem_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .action      (action),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .match_index (match_index)
);

`default_nettype wire
